// ===== design/rxs_pkg.sv =====
package rxs_pkg;

  // Record field widths
  localparam int unsigned KEY_W     = 10;
  localparam int unsigned TAG_W     = 16;
  localparam int unsigned REC_W     = KEY_W + TAG_W;
  localparam int unsigned DEPTH_DEF = 64;

  // Sequencer states
  typedef enum logic [2:0] {
    S_LOAD,
    S_RD_A,
    S_GET_A,
    S_CMP,
    S_WR_A,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_HOLD
  } rxs_state_t;

  // Strobes from the sequencer to the datapath
  typedef struct packed {
    logic ld_wr;
    logic cap_a;
    logic cmp;
    logic wr_a;
    logic cap_out;
    logic out_valid;
    logic out_last;
    logic dropped;
  } rxs_ctl_t;

endpackage

// ===== design/rxs_in_if.sv =====
interface rxs_in_if;
  import rxs_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] sort_key;
  logic [TAG_W-1:0] record_tag;
  logic             end_of_set;

  modport source (output valid, output sort_key, output record_tag, output end_of_set,
                  input ready);
  modport sink (input valid, input sort_key, input record_tag, input end_of_set,
                output ready);
endinterface

// ===== design/rxs_out_if.sv =====
interface rxs_out_if;
  import rxs_pkg::*;

  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] out_key;
  logic [TAG_W-1:0] out_tag;
  logic             out_last;
  logic             dropped_flag;

  modport source (output valid, output out_key, output out_tag, output out_last,
                  output dropped_flag, input ready);
  modport sink (input valid, input out_key, input out_tag, input out_last,
                input dropped_flag, output ready);
endinterface

// ===== design/record_exchange_sort_by_key_core.sv =====
// Record exchange sort by key.
// item_in takes one record per beat (sort_key, record_tag, end_of_set).
// Records are stored one per cycle while item_in.ready is high. The beat
// with end_of_set closes the set and is stored if room is left. Beyond
// DEPTH records further beats are taken and discarded, and every result
// of that set carries dropped_flag.
// After the closing beat the block sorts in place with one compare unit
// and one port pair of the record RAM, making n*(n-1)/2 compares for n
// records in the set. Then result_out gives all n records, largest key
// first, out_last on the final one; each result passes through a RAM
// read and the output register and then waits out any receiver stall.
// item_in.ready stays low throughout sort and emit.
// A stalled receiver holds the current result steady; nothing is lost.
// Synchronous reset returns the block to loading an empty set; RAM
// contents are left as they are and are rewritten before being read.
module record_exchange_sort_by_key_core #(
  parameter int unsigned DEPTH = rxs_pkg::DEPTH_DEF
) (
  input logic      clk,
  input logic      rst,
  rxs_in_if.sink   item_in,
  rxs_out_if.source result_out
);
  import rxs_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  rxs_ctl_t         ctl;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  logic [REC_W-1:0] rdata;
  logic [REC_W-1:0] wdata;
  logic             we;
  logic [KEY_W-1:0] rd_key;
  logic [TAG_W-1:0] rd_tag;
  logic [KEY_W-1:0] cur_key;
  logic [TAG_W-1:0] cur_tag;
  logic [KEY_W-1:0] out_key;
  logic [TAG_W-1:0] out_tag;
  logic             swap;

  rxs_seq #(.DEPTH(DEPTH)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_in.valid),
    .in_end    (item_in.end_of_set),
    .in_ready  (item_in.ready),
    .out_ready (result_out.ready),
    .ctl       (ctl),
    .waddr     (waddr),
    .raddr     (raddr)
  );

  rxs_ram #(.WIDTH(REC_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_key = rdata[REC_W-1:TAG_W];
  assign rd_tag = rdata[TAG_W-1:0];

  // Shared compare unit
  assign swap = cur_key > rd_key;

  // Store the incoming beat, or write back the held record
  assign wdata = ctl.ld_wr ? {item_in.sort_key, item_in.record_tag} : {cur_key, cur_tag};
  assign we    = ctl.ld_wr || (ctl.cmp && swap) || ctl.wr_a;

  // Hold the running minimum and the output record
  always_ff @(posedge clk) begin
    if (ctl.cap_a || (ctl.cmp && swap)) begin
      cur_key <= rd_key;
      cur_tag <= rd_tag;
    end
    if (ctl.cap_out) begin
      out_key <= rd_key;
      out_tag <= rd_tag;
    end
  end

  assign result_out.valid        = ctl.out_valid;
  assign result_out.out_key      = out_key;
  assign result_out.out_tag      = out_tag;
  assign result_out.out_last     = ctl.out_last;
  assign result_out.dropped_flag = ctl.dropped;

endmodule

// ===== design/rxs_ram.sv =====
module rxs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/rxs_seq.sv =====
module rxs_seq #(
  parameter int unsigned DEPTH = rxs_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_end,
  output logic                     in_ready,
  input  logic                     out_ready,
  output rxs_pkg::rxs_ctl_t        ctl,
  output logic [$clog2(DEPTH)-1:0] waddr,
  output logic [$clog2(DEPTH)-1:0] raddr
);
  import rxs_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  rxs_state_t    state, state_next;
  logic [CW-1:0] fill, fill_next;
  logic          ovf, ovf_next;
  logic [AW-1:0] a, a_next;
  logic [AW-1:0] b, b_next;
  logic [AW-1:0] idx, idx_next;
  logic          fire;
  logic          has_room;

  assign fire     = in_valid && (state == S_LOAD);
  assign has_room = fill < CW'(DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      fill  <= '0;
      ovf   <= 1'b0;
      a     <= '0;
      b     <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      ovf   <= ovf_next;
      a     <= a_next;
      b     <= b_next;
      idx   <= idx_next;
    end
  end

  // Next state, counters and strobes
  always_comb begin
    state_next = state;
    fill_next  = fill;
    ovf_next   = ovf;
    a_next     = a;
    b_next     = b;
    idx_next   = idx;
    in_ready   = 1'b0;
    ctl        = '0;
    ctl.dropped  = ovf;
    ctl.out_last = (idx == '0);
    waddr      = fill[AW-1:0];
    raddr      = a;
    unique case (state)
      S_LOAD: begin
        in_ready   = 1'b1;
        ctl.ld_wr  = fire && has_room;
        if (fire) begin
          if (has_room) begin
            fill_next = fill + CW'(1);
          end else begin
            ovf_next = 1'b1;
          end
          if (in_end) begin
            a_next   = '0;
            idx_next = AW'(fill_next - CW'(1));
            if (fill_next >= CW'(2)) begin
              state_next = S_RD_A;
            end else begin
              state_next = S_EMIT_RD;
            end
          end
        end
      end
      S_RD_A: begin
        raddr      = a;
        state_next = S_GET_A;
      end
      S_GET_A: begin
        ctl.cap_a  = 1'b1;
        raddr      = a + AW'(1);
        b_next     = a + AW'(1);
        state_next = S_CMP;
      end
      S_CMP: begin
        // Compare entry b against the held entry a, swap on strictly greater
        ctl.cmp = 1'b1;
        waddr   = b;
        raddr   = b + AW'(1);
        if (CW'(b) == fill - CW'(1)) begin
          state_next = S_WR_A;
        end else begin
          b_next = b + AW'(1);
        end
      end
      S_WR_A: begin
        ctl.wr_a = 1'b1;
        waddr    = a;
        a_next   = a + AW'(1);
        if (CW'(a) + CW'(2) == fill) begin
          idx_next   = AW'(fill - CW'(1));
          state_next = S_EMIT_RD;
        end else begin
          state_next = S_RD_A;
        end
      end
      S_EMIT_RD: begin
        raddr      = idx;
        state_next = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        ctl.cap_out = 1'b1;
        state_next  = S_EMIT_HOLD;
      end
      S_EMIT_HOLD: begin
        ctl.out_valid = 1'b1;
        raddr         = idx - AW'(1);
        if (out_ready) begin
          if (idx == '0) begin
            fill_next  = '0;
            ovf_next   = 1'b0;
            state_next = S_LOAD;
          end else begin
            idx_next   = idx - AW'(1);
            state_next = S_EMIT_LD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("fill count above capacity");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    ovf |-> fill == CW'(DEPTH))
    else $error("overflow flagged while store not full");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && ctl.out_valid))
    else $error("input and output open at once");

  a_cmp_order: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> (b > a) && (CW'(b) < fill))
    else $error("compare index out of order");

  a_run_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_HOLD && out_ready && idx == '0) |=> (fill == '0 && !ovf))
    else $error("set not cleared after final beat");
`endif

endmodule
